// ===== hdl/i5a_pkg.sv =====
package i5a_pkg;

  typedef enum logic [2:0] {
    KIND_ADD = 3'd1,
    KIND_SUB = 3'd2,
    KIND_MUL = 3'd3,
    KIND_DIV = 3'd4,
    KIND_MOD = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DIVZERO = 2'd1,
    ST_UNKNOWN = 2'd2
  } status_e;

  localparam int unsigned DataW    = 64;
  localparam int unsigned DivSteps = DataW;

  // one beat travelling down the divider chain
  typedef struct packed {
    logic              valid;
    logic              is_div;
    logic              is_mod;
    logic              neg_q;
    logic              neg_r;
    status_e           status;
    logic [DataW-1:0]  res;   // answer for add, sub, mul
    logic [DataW-1:0]  rem;   // partial remainder
    logic [DataW-1:0]  dd;    // dividend bits shifting out, quotient bits shifting in
    logic [DataW-1:0]  dv;    // divisor magnitude
  } stage_t;

endpackage

// ===== hdl/i5a_div_stage.sv =====
module i5a_div_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  i5a_pkg::stage_t d_i,
  output i5a_pkg::stage_t q_o
);

  i5a_pkg::stage_t          stage_d;
  i5a_pkg::stage_t          stage_q;
  logic                     valid_q;
  logic [i5a_pkg::DataW:0]  trial;
  logic [i5a_pkg::DataW:0]  diff;

  // one restoring division step
  always_comb begin
    stage_d = d_i;
    trial   = {d_i.rem, d_i.dd[i5a_pkg::DataW-1]};
    diff    = trial - {1'b0, d_i.dv};
    if (!diff[i5a_pkg::DataW]) begin
      stage_d.rem = diff[i5a_pkg::DataW-1:0];
      stage_d.dd  = {d_i.dd[i5a_pkg::DataW-2:0], 1'b1};
    end else begin
      stage_d.rem = trial[i5a_pkg::DataW-1:0];
      stage_d.dd  = {d_i.dd[i5a_pkg::DataW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= stage_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  // valid comes from the reset flop, the rest from the data flops
  always_comb begin
    q_o       = stage_q;
    q_o.valid = valid_q;
  end

endmodule

// ===== hdl/int64_five_op_alu.sv =====
// signed 64-bit alu: add, sub, mul (wrapping), div (truncating) and mod (sign of the
// dividend), one beat in and one beat out per cycle while the output is not stalled.
// every beat passes through 66 register stages: one decode stage holding the
// magnitudes and 32x32 partial products, 64 restoring divider stages (one quotient
// bit each, which sets the depth) and one output register. all operations travel
// the same chain so results leave in order. a stall on the output freezes the whole
// pipe; nothing is lost or repeated. divide by zero gives 0 with status 1, an unknown
// code 0 with status 2; most negative over minus one gives the most negative value,
// remainder 0.
module int64_five_op_alu (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [2:0]  kind_i,
  input  logic signed [63:0] left_operand_i,
  input  logic signed [63:0] right_operand_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic signed [63:0] answer_o,
  output logic [1:0]  status_o
);

  localparam int unsigned W = i5a_pkg::DataW;
  localparam int unsigned H = W / 2;

  logic advance;

  // decode stage registers
  logic              a_valid_q;
  logic              a_is_div_q, a_is_mod_q, a_is_mul_q, a_neg_q_q, a_neg_r_q;
  i5a_pkg::status_e  a_status_q, a_status_d;
  logic [W-1:0]      a_res_q, a_res_d;
  logic [W-1:0]      a_ma_q, a_mb_q;
  logic [W-1:0]      a_p0_q;
  logic [H-1:0]      a_p1_q, a_p2_q;

  logic              is_div_d, is_mod_d, is_mul_d;
  logic [W-1:0]      a_u, b_u;
  logic [W-1:0]      p0_full;
  logic [H-1:0]      p1_full, p2_full;

  i5a_pkg::stage_t   chain_head;
  i5a_pkg::stage_t   chain [0:i5a_pkg::DivSteps];

  // output register
  logic              out_valid_q;
  logic [W-1:0]      out_answer_q, out_answer_d;
  i5a_pkg::status_e  out_status_q, out_status_d;

  // whole pipe moves unless a finished beat is held back
  assign advance = !(out_valid_q && stall_i);
  assign stall_o = !advance;

  assign a_u = left_operand_i;
  assign b_u = right_operand_i;
  // only the low half of the cross products reaches the low 64 bits
  assign p0_full = {{H{1'b0}}, a_u[H-1:0]} * {{H{1'b0}}, b_u[H-1:0]};
  assign p1_full = a_u[H-1:0] * b_u[W-1:H];
  assign p2_full = a_u[W-1:H] * b_u[H-1:0];

  always_comb begin
    is_div_d   = 1'b0;
    is_mod_d   = 1'b0;
    is_mul_d   = 1'b0;
    a_status_d = i5a_pkg::ST_OK;
    a_res_d    = '0;
    case (kind_i)
      i5a_pkg::KIND_ADD: a_res_d = a_u + b_u;
      i5a_pkg::KIND_SUB: a_res_d = a_u - b_u;
      i5a_pkg::KIND_MUL: is_mul_d = 1'b1;
      i5a_pkg::KIND_DIV: begin
        is_div_d = 1'b1;
        if (b_u == '0) a_status_d = i5a_pkg::ST_DIVZERO;
      end
      i5a_pkg::KIND_MOD: begin
        is_mod_d = 1'b1;
        if (b_u == '0) a_status_d = i5a_pkg::ST_DIVZERO;
      end
      default: a_status_d = i5a_pkg::ST_UNKNOWN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (advance) begin
      a_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      a_is_div_q <= is_div_d;
      a_is_mod_q <= is_mod_d;
      a_is_mul_q <= is_mul_d;
      a_neg_q_q  <= a_u[W-1] ^ b_u[W-1];
      a_neg_r_q  <= a_u[W-1];
      a_status_q <= a_status_d;
      a_res_q    <= a_res_d;
      a_ma_q     <= a_u[W-1] ? (W'(0) - a_u) : a_u;
      a_mb_q     <= b_u[W-1] ? (W'(0) - b_u) : b_u;
      // low 64 bits of the product from three 32x32 partials
      a_p0_q     <= p0_full;
      a_p1_q     <= p1_full;
      a_p2_q     <= p2_full;
    end
  end

  // head of the divider chain, multiply partials summed here
  always_comb begin
    chain_head.valid  = a_valid_q;
    chain_head.is_div = a_is_div_q;
    chain_head.is_mod = a_is_mod_q;
    chain_head.neg_q  = a_neg_q_q;
    chain_head.neg_r  = a_neg_r_q;
    chain_head.status = a_status_q;
    chain_head.res    = a_is_mul_q ? (a_p0_q + {a_p1_q + a_p2_q, {H{1'b0}}}) : a_res_q;
    chain_head.rem    = '0;
    chain_head.dd     = a_ma_q;
    chain_head.dv     = a_mb_q;
  end

  assign chain[0] = chain_head;

  for (genvar g = 0; g < i5a_pkg::DivSteps; g++) begin : g_div
    i5a_div_stage u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (advance),
      .d_i    (chain[g]),
      .q_o    (chain[g+1])
    );
  end

  // sign fix-up and error override
  always_comb begin
    i5a_pkg::stage_t t;
    t = chain[i5a_pkg::DivSteps];
    out_status_d = t.status;
    if (t.status != i5a_pkg::ST_OK) begin
      out_answer_d = '0;
    end else if (t.is_div) begin
      out_answer_d = t.neg_q ? (W'(0) - t.dd) : t.dd;
    end else if (t.is_mod) begin
      out_answer_d = t.neg_r ? (W'(0) - t.rem) : t.rem;
    end else begin
      out_answer_d = t.res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= chain[i5a_pkg::DivSteps].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_answer_q <= out_answer_d;
      out_status_q <= out_status_d;
    end
  end

  assign valid_o  = out_valid_q;
  assign answer_o = out_answer_q;
  assign status_o = out_status_q;

endmodule
